### rtl/core/macia_pkg.sv
// Shared types, codes and constants of the MIDI ACIA register block.
package macia_pkg;

   // Item kinds carried on the request tuser.
   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_MODE = 2'd0,
      CSR_CD0  = 2'd1,
      CSR_CD1  = 2'd2,
      CSR_CD2  = 2'd3
   } csr_idx_type;

   // Interrupt routing kinds.
   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_IRQ  = 2'd1,
      KIND_NMI  = 2'd2
   } kind_type;

   localparam int unsigned CsrDataW = 16;

   localparam logic [7:0] ST_IRQ  = 8'h80;
   localparam logic [7:0] ST_OVRN = 8'h20;
   localparam logic [7:0] ST_TDRE = 8'h02;
   localparam logic [7:0] ST_RDRF = 8'h01;
   localparam logic [7:0] CT_RIE  = 8'h80;
   localparam logic [1:0] CD_RESET = 2'd3;
   localparam logic [7:0] CTRL_RESET = 8'h03;
   localparam logic [7:0] RD_EMPTY = 8'hff;

   localparam logic [1:0] PHASE_IDLE = 2'd0;
   localparam logic [1:0] PHASE_LAST = 2'd1;
   localparam logic [1:0] PHASE_SEND = 2'd2;

   localparam logic [15:0] PERIOD_CD0_RST = 16'd1;
   localparam logic [15:0] PERIOD_CD1_RST = 16'd31;
   localparam logic [15:0] PERIOD_CD2_RST = 16'd126;

   typedef struct packed {
      cmd_type     cmd;
      logic [3:0]  addr;
      logic [7:0]  wdata;
      logic        rx_valid;
      logic [7:0]  rx_byte;
   } item_type;

   typedef struct packed {
      logic [7:0]  rdata;
      logic        irq_line;
      logic        nmi_line;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        rx_taken;
   } result_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] period_cd0;
      logic [15:0] period_cd1;
      logic [15:0] period_cd2;
   } cfg_type;

   typedef struct packed {
      logic [3:0]  ctrl_a;
      logic [3:0]  stat_a;
      logic [3:0]  tx_a;
      logic [3:0]  rx_a;
      kind_type    kind;
   } map_type;

   // Register address map and interrupt kind for each interface mode.
   function automatic map_type mode_map(input logic [1:0] mode);
      map_type m;
      unique case (mode)
         2'd0:    m = '{ctrl_a: 4'd0, stat_a: 4'd2, tx_a: 4'd1, rx_a: 4'd3, kind: KIND_IRQ};
         2'd1:    m = '{ctrl_a: 4'd8, stat_a: 4'd8, tx_a: 4'd9, rx_a: 4'd9, kind: KIND_IRQ};
         2'd2:    m = '{ctrl_a: 4'd4, stat_a: 4'd6, tx_a: 4'd5, rx_a: 4'd7, kind: KIND_IRQ};
         default: m = '{ctrl_a: 4'd0, stat_a: 4'd2, tx_a: 4'd1, rx_a: 4'd3, kind: KIND_NMI};
      endcase
      return m;
   endfunction

endpackage

### rtl/core/macia_csr.sv
// Configuration registers: interface mode and the three character periods.
module macia_csr
   import macia_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [1:0]          csr_addr,
   input  logic [CsrDataW-1:0] csr_wdata,
   output cfg_type             cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_MODE: cfg_in.mode       = csr_wdata[1:0];
            CSR_CD0:  cfg_in.period_cd0 = csr_wdata[15:0];
            CSR_CD1:  cfg_in.period_cd1 = csr_wdata[15:0];
            CSR_CD2:  cfg_in.period_cd2 = csr_wdata[15:0];
            default:  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode       <= 2'd0;
         cfg_ff.period_cd0 <= PERIOD_CD0_RST;
         cfg_ff.period_cd1 <= PERIOD_CD1_RST;
         cfg_ff.period_cd2 <= PERIOD_CD2_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/macia_core.sv
// ACIA register state and the one-pass update for a read, write or tick.
module macia_core
   import macia_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type res
);

   logic [7:0]  control_ff, control_in;
   logic [7:0]  status_ff, status_in;
   logic [7:0]  receive_ff, receive_in;
   logic [7:0]  transmit_ff, transmit_in;
   logic [1:0]  phase_ff, phase_in;
   logic        pend_ff, pend_in;
   logic [15:0] count_ff, count_in;
   logic        run_ff, run_in;

   map_type     amap;
   logic [15:0] period_sel;
   logic [15:0] period;

   assign amap = mode_map(cfg.mode);

   // Character period for the current counter divide select; zero acts as one.
   always_comb begin
      unique case (control_ff[1:0])
         2'd0:    period_sel = cfg.period_cd0;
         2'd1:    period_sel = cfg.period_cd1;
         2'd2:    period_sel = cfg.period_cd2;
         default: period_sel = 16'd1;
      endcase
      period = (period_sel == 16'd0) ? 16'd1 : period_sel;
   end

   always_comb begin
      control_in  = control_ff;
      status_in   = status_ff;
      receive_in  = receive_ff;
      transmit_in = transmit_ff;
      phase_in    = phase_ff;
      pend_in     = pend_ff;
      count_in    = count_ff;
      run_in      = run_ff;
      res         = '0;

      unique case (item.cmd)
         CMD_READ: begin
            res.rdata = RD_EMPTY;
            if (item.addr == amap.stat_a) begin
               res.rdata = status_ff;
            end else if (item.addr == amap.rx_a) begin
               status_in = status_in & ~ST_OVRN;
               if (pend_ff) begin
                  status_in = status_in & ~ST_IRQ;
                  pend_in   = 1'b0;
               end
               if ((status_ff & ST_RDRF) != 8'd0) begin
                  status_in = status_in & ~ST_RDRF;
                  res.rdata = receive_ff;
               end
            end
         end
         CMD_WRITE: begin
            if (item.addr == amap.ctrl_a) begin
               if (item.wdata[1:0] != CD_RESET) begin
                  control_in = item.wdata;
                  if (phase_ff == PHASE_IDLE) begin
                     count_in = 16'd1;
                     run_in   = 1'b1;
                  end
               end else begin
                  // Master reset: data registers stay.
                  control_in = CTRL_RESET;
                  status_in  = ST_TDRE;
                  phase_in   = PHASE_IDLE;
                  run_in     = 1'b0;
                  count_in   = 16'd0;
                  pend_in    = 1'b0;
               end
            end else if (item.addr == amap.tx_a) begin
               status_in = status_in & ~ST_IRQ;
               if ((status_ff & ST_TDRE) != 8'd0 && control_ff[1:0] != CD_RESET) begin
                  status_in   = status_in & ~ST_TDRE;
                  transmit_in = item.wdata;
                  if (phase_ff == PHASE_IDLE) begin
                     count_in = 16'd1;
                     run_in   = 1'b1;
                     phase_in = PHASE_SEND;
                  end else if (phase_ff == PHASE_LAST) begin
                     phase_in = PHASE_SEND;
                  end
               end
            end
         end
         CMD_TICK: begin
            if (run_ff) begin
               if (count_ff > 16'd1) begin
                  count_in = count_ff - 16'd1;
               end else begin
                  if (phase_ff == PHASE_SEND) begin
                     res.tx_valid = 1'b1;
                     res.tx_byte  = transmit_ff;
                     status_in    = status_in | ST_TDRE;
                  end
                  if (phase_ff != PHASE_IDLE) begin
                     phase_in = phase_ff - 2'd1;
                  end
                  if ((status_ff & ST_RDRF) == 8'd0 && item.rx_valid) begin
                     receive_in   = item.rx_byte;
                     status_in    = status_in | ST_RDRF;
                     res.rx_taken = 1'b1;
                     if ((control_ff & CT_RIE) != 8'd0) begin
                        status_in = status_in | ST_IRQ;
                        pend_in   = 1'b1;
                     end
                  end
                  count_in = period;
               end
            end
         end
         default: ;
      endcase

      res.irq_line = pend_in && (amap.kind == KIND_IRQ);
      res.nmi_line = pend_in && (amap.kind == KIND_NMI);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff  <= CTRL_RESET;
         status_ff   <= ST_TDRE;
         receive_ff  <= 8'd0;
         transmit_ff <= 8'd0;
         phase_ff    <= PHASE_IDLE;
         pend_ff     <= 1'b0;
         count_ff    <= 16'd0;
         run_ff      <= 1'b0;
      end else if (fire) begin
         control_ff  <= control_in;
         status_ff   <= status_in;
         receive_ff  <= receive_in;
         transmit_ff <= transmit_in;
         phase_ff    <= phase_in;
         pend_ff     <= pend_in;
         count_ff    <= count_in;
         run_ff      <= run_in;
      end
   end

endmodule

### rtl/core/midi_acia_register_block_unit.sv
// Top level of the MIDI ACIA register block: stream ports, input and result registers.
//
// A 6850-style serial interface as found on MIDI cartridges. Each request beat
// is one bus read, one bus write or one CPU cycle tick (req_tuser), and each
// gives exactly one response beat with read data, the interrupt lines as seen
// after the beat, any byte sent to MIDI out, and whether the offered MIDI-in
// byte was latched. A beat is held in an input register, runs through one
// pass of register-update logic and lands in a result register, so a new
// beat is taken every clock while the result side keeps up. The response
// shows rsp_tvalid once its beat has moved from the input register into the
// result register; a stalled response holds it back. The input register
// keeps accepting while a finished response waits, up to one beat in each
// stage. The configuration port writes the interface mode (address map and
// IRQ/NMI routing) and the three character periods; write it only while no
// beat is in flight.
module midi_acia_register_block_unit
   import macia_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // addr[3:0], wdata[11:4], rx_valid[12], rx_byte[20:13]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // rdata[7:0], irq_line[8], nmi_line[9], tx_valid[10],
                                    // tx_byte[18:11], rx_taken[19]
   // configuration write port
   input  logic        csr_we,
   input  logic [1:0]  csr_addr,
   input  logic [15:0] csr_wdata
);

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       in_vld_ff;
   result_type res_ff, res_in;
   logic       out_vld_ff;
   logic       advance;
   logic       take;

   // Unpack the request beat.
   always_comb begin
      item_in.cmd      = cmd_type'(req_tuser);
      item_in.addr     = req_tdata[3:0];
      item_in.wdata    = req_tdata[11:4];
      item_in.rx_valid = req_tdata[12];
      item_in.rx_byte  = req_tdata[20:13];
   end

   // Advance when the result register is free or being drained this cycle.
   assign advance    = in_vld_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign take       = req_tvalid && req_tready;

   macia_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   macia_core u_core (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .item  (item_ff),
      .cfg   (cfg),
      .res   (res_in)
   );

   // Input register: hold the beat until the core consumes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   // Result register: load on advance, drop once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {4'd0, res_ff.rx_taken, res_ff.tx_byte, res_ff.tx_valid,
                        res_ff.nmi_line, res_ff.irq_line, res_ff.rdata};

endmodule

### verif/midi_acia_register_block_unit_tb.sv
// Self-checking testbench for the MIDI ACIA register block: directed table, then random phases.
module midi_acia_register_block_unit_tb;
   import macia_pkg::*;

   // Item kind that the block must ignore: no state change, quiet outputs.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Interface modes.
   localparam logic [1:0] MODE_STD  = 2'd0;
   localparam logic [1:0] MODE_HIGH = 2'd1;
   localparam logic [1:0] MODE_MID  = 2'd2;
   localparam logic [1:0] MODE_NMI  = 2'd3;

   // Register addresses of the standard map, the high map and the middle map.
   localparam logic [3:0] A0_CTRL = 4'd0;
   localparam logic [3:0] A0_TX   = 4'd1;
   localparam logic [3:0] A0_STAT = 4'd2;
   localparam logic [3:0] A0_RX   = 4'd3;
   localparam logic [3:0] A1_CTRL_STAT = 4'd8;
   localparam logic [3:0] A1_TX_RX     = 4'd9;
   localparam logic [3:0] A2_CTRL = 4'd4;
   localparam logic [3:0] A2_TX   = 4'd5;
   localparam logic [3:0] A2_STAT = 4'd6;
   localparam logic [3:0] A2_RX   = 4'd7;
   localparam logic [3:0] A_TOP   = 4'hf;

   localparam int STALL_LIMIT = 4000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 235;

   typedef struct packed {
      logic [1:0] cmd;
      logic [3:0] addr;
      logic [7:0] wdata;
      logic       rx_valid;
      logic [7:0] rx_byte;
   } bus_op_t;

   // One row of the directed table; fixed rows carry a hand-written read value
   // and expect every other response field to be zero.
   typedef struct packed {
      bus_op_t    op;
      logic       fixed;
      logic [7:0] fixed_rdata;
   } dir_row_t;

   // Directed part, all in the standard map with the reset periods.
   localparam dir_row_t DIR_TAB [24] = '{
      // straight out of reset: status shows TDRE, empty receive reads all ones
      '{'{CMD_READ,   A0_STAT, 8'h00, 1'b0, 8'h00}, 1'b1, 8'h02},
      '{'{CMD_READ,   A0_RX,   8'h00, 1'b0, 8'h00}, 1'b1, 8'hff},
      '{'{CMD_READ,   A_TOP,   8'h00, 1'b0, 8'h00}, 1'b1, 8'hff},
      '{'{CMD_READ,   A0_CTRL, 8'h00, 1'b0, 8'h00}, 1'b1, 8'hff},
      // transmit refused while in master reset, tick ignored while the timer is off
      '{'{CMD_WRITE,  A0_TX,   8'haa, 1'b0, 8'h00}, 1'b1, 8'h00},
      '{'{CMD_TICK,   A0_CTRL, 8'h00, 1'b1, 8'h55}, 1'b1, 8'h00},
      '{'{CMD_UNUSED, A_TOP,   8'hff, 1'b1, 8'hff}, 1'b1, 8'h00},
      // RIE on, shortest period: send a byte and latch one in the same event
      '{'{CMD_WRITE,  A0_CTRL, 8'h80, 1'b0, 8'h00}, 1'b0, 8'h00},
      '{'{CMD_WRITE,  A0_TX,   8'hff, 1'b0, 8'h00}, 1'b0, 8'h00},
      '{'{CMD_READ,   A0_STAT, 8'h00, 1'b0, 8'h00}, 1'b0, 8'h00},
      '{'{CMD_TICK,   A0_CTRL, 8'h00, 1'b1, 8'hff}, 1'b0, 8'h00},
      // RDRF still set: the offered byte is refused
      '{'{CMD_TICK,   A0_CTRL, 8'h00, 1'b1, 8'h00}, 1'b0, 8'h00},
      '{'{CMD_READ,   A0_STAT, 8'h00, 1'b0, 8'h00}, 1'b0, 8'h00},
      // transmit write drops status bit 7 but leaves the interrupt pending
      '{'{CMD_WRITE,  A0_TX,   8'h00, 1'b0, 8'h00}, 1'b0, 8'h00},
      '{'{CMD_READ,   A0_RX,   8'h00, 1'b0, 8'h00}, 1'b0, 8'h00},
      '{'{CMD_TICK,   A0_CTRL, 8'h00, 1'b0, 8'h00}, 1'b0, 8'h00},
      '{'{CMD_TICK,   A0_CTRL, 8'h00, 1'b1, 8'h00}, 1'b0, 8'h00},
      // master reset with an interrupt pending, receive data kept but flagged empty
      '{'{CMD_WRITE,  A0_CTRL, 8'h03, 1'b0, 8'h00}, 1'b0, 8'h00},
      '{'{CMD_READ,   A0_RX,   8'h00, 1'b0, 8'h00}, 1'b0, 8'h00},
      // longer divide, no RIE: first event right away, then the countdown
      '{'{CMD_WRITE,  A0_CTRL, 8'h01, 1'b0, 8'h00}, 1'b0, 8'h00},
      '{'{CMD_WRITE,  A0_TX,   8'h5a, 1'b0, 8'h00}, 1'b0, 8'h00},
      '{'{CMD_TICK,   A0_CTRL, 8'h00, 1'b1, 8'ha5}, 1'b0, 8'h00},
      '{'{CMD_TICK,   A0_CTRL, 8'h00, 1'b0, 8'h00}, 1'b0, 8'h00},
      '{'{CMD_READ,   A0_RX,   8'h00, 1'b0, 8'h00}, 1'b0, 8'h00}
   };

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // addr[3:0], wdata[11:4], rx_valid[12], rx_byte[20:13]
   logic [1:0]  req_tuser  = '0;   // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // rdata[7:0], irq_line[8], nmi_line[9], tx_valid[10],
                                   // tx_byte[18:11], rx_taken[19]
   logic        csr_we     = 1'b0;
   logic [1:0]  csr_addr   = '0;
   logic [15:0] csr_wdata  = '0;

   // Mirror of the block: configuration and register state.
   logic [1:0]  acia_mode;
   logic [15:0] per_cd [3];
   logic [7:0]  acia_ctrl, acia_stat, acia_rxd, acia_txd;
   logic [1:0]  acia_phase;
   logic        acia_irq;
   logic [15:0] acia_count;
   logic        acia_run;

   result_type  rsp_due [$];       // responses still owed by the block, oldest first
   int          fail_count = 0;
   int          snd_idle   = 0;    // percent of cycles the sender holds back
   int          rcv_idle   = 0;    // percent of cycles the receiver stalls
   int          stall_left = 0;    // long receiver hold-off, counted down by the receiver

   midi_acia_register_block_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Address map and interrupt routing for an interface mode.
   function automatic map_type acia_map(input logic [1:0] mode);
      map_type m;
      m.kind = (mode == MODE_NMI) ? KIND_NMI : KIND_IRQ;
      case (mode)
         MODE_HIGH: begin
            m.ctrl_a = A1_CTRL_STAT;
            m.stat_a = A1_CTRL_STAT;
            m.tx_a   = A1_TX_RX;
            m.rx_a   = A1_TX_RX;
         end
         MODE_MID: begin
            m.ctrl_a = A2_CTRL;
            m.stat_a = A2_STAT;
            m.tx_a   = A2_TX;
            m.rx_a   = A2_RX;
         end
         default: begin
            m.ctrl_a = A0_CTRL;
            m.stat_a = A0_STAT;
            m.tx_a   = A0_TX;
            m.rx_a   = A0_RX;
         end
      endcase
      return m;
   endfunction

   // Master reset: data registers survive, everything else goes back to idle.
   function automatic void acia_master_reset();
      acia_ctrl  = CTRL_RESET;
      acia_stat  = ST_TDRE;
      acia_phase = PHASE_IDLE;
      acia_run   = 1'b0;
      acia_count = '0;
      acia_irq   = 1'b0;
   endfunction

   // Advance the mirror by one bus item and return the response it owes.
   function automatic result_type acia_step(input bus_op_t op);
      result_type r;
      map_type    m;
      logic [15:0] per;
      r = '0;
      m = acia_map(acia_mode);
      case (op.cmd)
         CMD_READ: begin
            r.rdata = RD_EMPTY;
            if (op.addr == m.stat_a) begin
               r.rdata = acia_stat;
            end else if (op.addr == m.rx_a) begin
               // receive read clears overrun, then the interrupt, then hands out the byte
               acia_stat &= ~ST_OVRN;
               if (acia_irq) begin
                  acia_stat &= ~ST_IRQ;
                  acia_irq = 1'b0;
               end
               if ((acia_stat & ST_RDRF) != 0) begin
                  acia_stat &= ~ST_RDRF;
                  r.rdata = acia_rxd;
               end
            end
         end
         CMD_WRITE: begin
            if (op.addr == m.ctrl_a) begin
               acia_ctrl = op.wdata;
               if (op.wdata[1:0] == CD_RESET) begin
                  acia_master_reset();
               end else if (acia_phase == PHASE_IDLE) begin
                  acia_count = 16'd1;
                  acia_run   = 1'b1;
               end
            end else if (op.addr == m.tx_a) begin
               acia_stat &= ~ST_IRQ;
               if ((acia_stat & ST_TDRE) != 0 && acia_ctrl[1:0] != CD_RESET) begin
                  acia_stat &= ~ST_TDRE;
                  acia_txd = op.wdata;
                  if (acia_phase == PHASE_IDLE) begin
                     acia_count = 16'd1;
                     acia_run   = 1'b1;
                     acia_phase = PHASE_SEND;
                  end else if (acia_phase == PHASE_LAST) begin
                     acia_phase = PHASE_SEND;
                  end
               end
            end
         end
         CMD_TICK: begin
            if (acia_run) begin
               if (acia_count > 16'd1) begin
                  acia_count--;
               end else begin
                  // character event
                  if (acia_phase == PHASE_SEND) begin
                     r.tx_valid = 1'b1;
                     r.tx_byte  = acia_txd;
                     acia_stat |= ST_TDRE;
                  end
                  if (acia_phase != PHASE_IDLE)
                     acia_phase--;
                  if ((acia_stat & ST_RDRF) == 0 && op.rx_valid) begin
                     acia_rxd   = op.rx_byte;
                     acia_stat |= ST_RDRF;
                     r.rx_taken = 1'b1;
                     if ((acia_ctrl & CT_RIE) != 0) begin
                        acia_stat |= ST_IRQ;
                        acia_irq = 1'b1;
                     end
                  end
                  per = (acia_ctrl[1:0] == CD_RESET) ? 16'd1 : per_cd[acia_ctrl[1:0]];
                  acia_count = (per == 16'd0) ? 16'd1 : per;
               end
            end
         end
         default: ;
      endcase
      r.irq_line = acia_irq && m.kind == KIND_IRQ;
      r.nmi_line = acia_irq && m.kind == KIND_NMI;
      return r;
   endfunction

   // Random item, weighted toward well-formed traffic on the current map.
   function automatic bus_op_t rand_op();
      bus_op_t     op;
      map_type     m;
      int unsigned pick;
      int unsigned sel;
      m = acia_map(acia_mode);
      op.cmd      = CMD_TICK;
      op.addr     = 4'($urandom_range(15));
      op.wdata    = 8'($urandom_range(255));
      op.rx_valid = ($urandom_range(99) < 60);
      op.rx_byte  = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 45) begin
         op.cmd = CMD_TICK;
      end else if (pick < 65) begin
         op.cmd = CMD_READ;
         if ($urandom_range(9) < 7)
            op.addr = $urandom_range(1) ? m.stat_a : m.rx_a;
      end else if (pick < 85) begin
         op.cmd = CMD_WRITE;
         sel = $urandom_range(9);
         if (sel < 4) begin
            // mostly a running divide, now and then a master reset
            op.addr = m.ctrl_a;
            if ($urandom_range(9) != 0)
               op.wdata[1:0] = 2'($urandom_range(2));
         end else if (sel < 9) begin
            op.addr = m.tx_a;
         end
      end else if (pick < 98) begin
         // noise: any legal kind with unshaped fields
         op.cmd = 2'($urandom_range(2));
      end else begin
         op.cmd = CMD_UNUSED;
      end
      return op;
   endfunction

   // Offer one beat, wait for the handshake, then log what the block owes for it.
   task automatic push_op(input bus_op_t op, input logic fixed, input logic [7:0] fixed_rdata);
      result_type want;
      while ($urandom_range(99) < snd_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, op.rx_byte, op.rx_valid, op.wdata, op.addr};
      req_tuser  <= op.cmd;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      want = acia_step(op);
      if (fixed) begin
         want       = '0;
         want.rdata = fixed_rdata;
      end
      rsp_due.push_back(want);
   endtask

   // Drop valid and hold until every owed response has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      do
         @(posedge clock);
      while (rsp_due.size() != 0);
   endtask

   // Rewrite all four registers while the block sits idle.
   task automatic load_config(input logic [1:0] mode, input logic [15:0] p0,
                              input logic [15:0] p1, input logic [15:0] p2);
      csr_idx_type idx [4] = '{CSR_MODE, CSR_CD0, CSR_CD1, CSR_CD2};
      logic [15:0] val [4];
      val = '{{14'd0, mode}, p0, p1, p2};
      drain();
      // let the pipeline settle past the last response
      repeat (3) @(posedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
      end
      csr_we    <= 1'b0;
      acia_mode = mode;
      per_cd    = '{p0, p1, p2};
   endtask

   function automatic void check_field(input string name, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   // Receiver: random stalls, plus a long hold-off when the stimulus asks for one.
   initial begin
      forever begin
         @(posedge clock);
         if (stall_left != 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rcv_idle);
         end
      end
   end

   // Response checker: compare each accepted beat with the oldest owed response.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_due.size() == 0) begin
            $display("%0t: response beat %h with nothing expected", $time, rsp_tdata);
            fail_count++;
         end else begin
            want = rsp_due.pop_front();
            check_field("rdata",    want.rdata,    rsp_tdata[7:0]);
            check_field("irq_line", want.irq_line, rsp_tdata[8]);
            check_field("nmi_line", want.nmi_line, rsp_tdata[9]);
            check_field("tx_valid", want.tx_valid, rsp_tdata[10]);
            check_field("tx_byte",  want.tx_byte,  rsp_tdata[18:11]);
            check_field("rx_taken", want.rx_taken, rsp_tdata[19]);
         end
      end
   end

   // Watchdog: end the run when no beat or register write moves for too long.
   initial begin
      int quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet = 0;
         else
            quiet++;
      end
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("midi_acia_register_block_unit_tb: FAIL");
      $finish;
   end

   // Stimulus: directed table, then eight random phases over all modes and idling mixes.
   initial begin
      logic [15:0] pa, pb, pc;
      acia_mode = MODE_STD;
      per_cd    = '{PERIOD_CD0_RST, PERIOD_CD1_RST, PERIOD_CD2_RST};
      acia_rxd  = '0;
      acia_txd  = '0;
      acia_master_reset();
      snd_idle  = 7;
      rcv_idle  = 64;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < $size(DIR_TAB); i++)
         push_op(DIR_TAB[i].op, DIR_TAB[i].fixed, DIR_TAB[i].fixed_rdata);

      for (int p = 0; p < PHASES; p++) begin
         // swap the idling mix, then run flat out for the last phases
         if (p == 3) begin
            snd_idle = 64;
            rcv_idle = 7;
         end else if (p == 6) begin
            snd_idle = 0;
            rcv_idle = 0;
         end
         // mostly short periods so character events come often; extremes now and then
         pa = 16'($urandom_range(6, 1));
         pb = 16'($urandom_range(6, 1));
         pc = 16'($urandom_range(6, 1));
         if (p == 1) begin
            pa = 16'hffff;
            pb = 16'd1;
         end else if (p == 3) begin
            pb = 16'hffff;
            pc = 16'd1;
         end else if (p == 5) begin
            pc = 16'hffff;
            pa = 16'd1;
         end
         load_config(2'(p), pa, pb, pc);

         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // hold the receiver off so both stages fill and the input backs up
            if (p == 1 && i == 100)
               stall_left = HOLD_CYCLES;
            // pause the sender until the block has caught up completely
            if (p == 4 && i == 120)
               drain();
            push_op(rand_op(), 1'b0, 8'h00);
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("midi_acia_register_block_unit_tb: PASS");
      else
         $display("midi_acia_register_block_unit_tb: FAIL");
      $finish;
   end

endmodule

### filelist.f
rtl/core/macia_pkg.sv
rtl/core/macia_csr.sv
rtl/core/macia_core.sv
rtl/core/midi_acia_register_block_unit.sv
verif/midi_acia_register_block_unit_tb.sv
